// ===== hw/rtl/dpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the divisor pair enumerator.
// No dependencies; imported by dpe_divider and divisor_pair_enumerator.
package dpe_pkg;

   // Width of the number port and of the large divisor.
   localparam int IN_W    = 16;
   // Number of low input bits that take part in the enumeration.
   localparam int NUM_W   = 16;
   // Width of a trial divisor: it never exceeds the square root of the number, plus one.
   localparam int D_W     = NUM_W / 2 + 1;
   // Width of the small divisor port.
   localparam int SMALL_W = 9;
   // Step counter of the divider, able to hold NUM_W itself.
   localparam int CNT_W   = $clog2(NUM_W + 1);

   // Status from the divider to the sequencer.
   typedef struct packed {
      logic done;    // one-cycle pulse when quotient and remainder are valid
      logic exact;   // remainder is zero
   } div_status_type;

endpackage

// ===== hw/rtl/dpe_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider producing one quotient bit per cycle.
// Depends on dpe_pkg for widths and the status struct.
module dpe_divider
   import dpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     dividend,
   input  logic [D_W-1:0]       divisor,
   output div_status_type       status,
   output logic [NUM_W-1:0]     quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W:0]     rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0]   div_ff, div_in;
   logic [D_W:0]     rem_shift;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff[D_W-1:0], quo_ff[NUM_W-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_shift - {1'b0, div_ff} : rem_shift;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.done  = done_ff;
   assign status.exact = (rem_ff == '0);
   assign quotient     = quo_ff;

endmodule

// ===== hw/rtl/divisor_pair_enumerator.sv =====
`timescale 1ns / 1ps
// Divisor pair enumerator: lists (d, n/d) for every divisor d with d*d <= n.
// Each trial goes through divider start, 16 quotient bits and the decision; a pair adds a push step.
// One number at a time: a new number waits until the last one's final word is registered.
// Output stalls lengthen an enumeration. A zero goes via the pending word to the output word.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output word.
// Depends on dpe_pkg and dpe_divider.
module divisor_pair_enumerator
   import dpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [IN_W-1:0]    req_number_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SMALL_W-1:0] rsp_small_divisor,
   output logic [IN_W-1:0]    rsp_large_divisor,
   output logic               rsp_last_pair,
   output logic               rsp_no_divisors
);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_PUSH  = 5'b01000,
      ST_FINAL = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [NUM_W-1:0]   number_ff, number_in;
   logic [D_W-1:0]     trial_ff, trial_in;

   // The pending pair is held back by one, so that the final one can carry the last flag.
   logic               pend_valid_ff, pend_valid_in;
   logic [D_W-1:0]     pend_small_ff, pend_small_in;
   logic [NUM_W-1:0]   pend_large_ff, pend_large_in;
   logic               pend_empty_ff, pend_empty_in;

   // Output word register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SMALL_W-1:0] rsp_small_ff, rsp_small_in;
   logic [IN_W-1:0]    rsp_large_ff, rsp_large_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               div_start;
   div_status_type     div_status;
   logic [NUM_W-1:0]   div_quotient;
   logic               out_free;
   logic               beyond_root;

   dpe_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (number_ff),
      .divisor  (trial_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // The output register can take a new word when empty or when its word leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // d*d <= n holds exactly when d <= n/d, so the quotient itself ends the search.
   assign beyond_root = div_quotient < NUM_W'(trial_ff);

   always_comb begin
      state_in      = state_ff;
      number_in     = number_ff;
      trial_in      = trial_ff;
      pend_valid_in = pend_valid_ff;
      pend_small_in = pend_small_ff;
      pend_large_in = pend_large_ff;
      pend_empty_in = pend_empty_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_small_in  = rsp_small_ff;
      rsp_large_in  = rsp_large_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               number_in = req_number_in[NUM_W-1:0];
               trial_in  = D_W'(1);
               if (req_number_in[NUM_W-1:0] == '0) begin
                  // Zero has no pairs: a single empty word is queued as the final one.
                  pend_valid_in = 1'b1;
                  pend_small_in = '0;
                  pend_large_in = '0;
                  pend_empty_in = 1'b1;
                  state_in      = ST_FINAL;
               end else begin
                  pend_valid_in = 1'b0;
                  pend_empty_in = 1'b0;
                  state_in      = ST_START;
               end
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               if (beyond_root) begin
                  state_in = ST_FINAL;
               end else if (div_status.exact) begin
                  state_in = ST_PUSH;
               end else begin
                  trial_in = trial_ff + D_W'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_PUSH: begin
            // A new pair displaces the pending one, which then goes out as an ordinary word.
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_small_in = SMALL_W'(pend_small_ff);
                  rsp_large_in = IN_W'(pend_large_ff);
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = pend_empty_ff;
               end
               pend_valid_in = 1'b1;
               pend_small_in = trial_ff;
               pend_large_in = div_quotient;
               trial_in      = trial_ff + D_W'(1);
               state_in      = ST_START;
            end
         end
         ST_FINAL: begin
            // One always divides a nonzero number, so a pending word exists here.
            if (out_free) begin
               rsp_valid_in  = pend_valid_ff;
               rsp_small_in  = SMALL_W'(pend_small_ff);
               rsp_large_in  = IN_W'(pend_large_ff);
               rsp_last_in   = 1'b1;
               rsp_empty_in  = pend_empty_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         number_ff     <= '0;
         trial_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         number_ff     <= number_in;
         trial_ff      <= trial_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_small_ff <= pend_small_in;
      pend_large_ff <= pend_large_in;
      pend_empty_ff <= pend_empty_in;
      rsp_small_ff  <= rsp_small_in;
      rsp_large_ff  <= rsp_large_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // A new number is taken only while the sequencer is idle.
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_small_divisor = rsp_small_ff;
   assign rsp_large_divisor = rsp_large_ff;
   assign rsp_last_pair     = rsp_last_ff;
   assign rsp_no_divisors   = rsp_empty_ff;

endmodule

// ===== tb/divisor_pair_enumerator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for divisor_pair_enumerator: directed table, then random numbers.
// Depends on dpe_pkg and on the divisor_pair_enumerator RTL with its divider.
module divisor_pair_enumerator_tb;
   import dpe_pkg::*;

   // One result word as the block presents it on the rsp_ channel.
   typedef struct packed {
      logic [SMALL_W-1:0] small_div;
      logic [IN_W-1:0]    large_div;
      logic               last;
      logic               empty;
   } pair_word_type;

   // One row of the directed table. Where listed is set, the word is typed in by hand
   // and stands in for the predictor; it is only used for numbers with a single result word.
   typedef struct packed {
      logic [IN_W-1:0] number;
      logic            listed;
      pair_word_type   word;
   } number_row_type;

   localparam int            RANDOM_ITEMS = 112;
   localparam int            CYCLE_LIMIT  = 4_000_000;
   localparam int            HOLD_CYCLES  = 600;
   localparam int            DRAIN_CYCLES = 200;
   localparam int            NUM_ROWS     = 19;
   localparam pair_word_type NO_WORD      = '0;

   logic               clock;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic [IN_W-1:0]    req_number_in     = '0;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic [SMALL_W-1:0] rsp_small_divisor;
   logic [IN_W-1:0]    rsp_large_divisor;
   logic               rsp_last_pair;
   logic               rsp_no_divisors;

   pair_word_type pending_pairs[$];   // expected words, oldest first
   int            mismatch_count = 0;
   int            numbers_taken  = 0;
   int            cycle_count    = 0;
   logic          hold_off       = 1'b0;

   // The directed part: zero and one, small primes, the largest prime, the largest
   // perfect square (root repeated), the number with the most pairs, the top bit on
   // its own, alternating bit patterns, all ones, and zeros back to back.
   number_row_type directed_rows [NUM_ROWS] = '{
      {16'd0,     1'b1, 9'd0, 16'd0,     1'b1, 1'b1},
      {16'd1,     1'b1, 9'd1, 16'd1,     1'b1, 1'b0},
      {16'd2,     1'b1, 9'd1, 16'd2,     1'b1, 1'b0},
      {16'd3,     1'b1, 9'd1, 16'd3,     1'b1, 1'b0},
      {16'd4,     1'b0, NO_WORD},
      {16'd36,    1'b0, NO_WORD},
      {16'd256,   1'b0, NO_WORD},
      {16'd257,   1'b1, 9'd1, 16'd257,   1'b1, 1'b0},
      {16'd65521, 1'b1, 9'd1, 16'd65521, 1'b1, 1'b0},
      {16'd65535, 1'b0, NO_WORD},
      {16'd65534, 1'b0, NO_WORD},
      {16'd65025, 1'b0, NO_WORD},
      {16'd55440, 1'b0, NO_WORD},
      {16'h8000,  1'b0, NO_WORD},
      {16'hAAAA,  1'b0, NO_WORD},
      {16'h5555,  1'b0, NO_WORD},
      {16'd0,     1'b1, 9'd0, 16'd0,     1'b1, 1'b1},
      {16'd0,     1'b1, 9'd0, 16'd0,     1'b1, 1'b1},
      {16'd1,     1'b1, 9'd1, 16'd1,     1'b1, 1'b0}
   };

   divisor_pair_enumerator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_number_in     (req_number_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_small_divisor (rsp_small_divisor),
      .rsp_large_divisor (rsp_large_divisor),
      .rsp_last_pair     (rsp_last_pair),
      .rsp_no_divisors   (rsp_no_divisors)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Trial division over the masked number. Every pair (d, n/d) with d*d <= n is
   // queued in ascending order of d, and the final one carries the last flag. A zero
   // gives a single word that is both empty and last.
   function automatic void enumerate_pairs(input logic [IN_W-1:0] raw);
      int unsigned   n;
      int unsigned   d;
      int unsigned   divisors[$];
      pair_word_type word;
      n = raw & ((32'd1 << NUM_W) - 32'd1);
      if (n == 0) begin
         word = '{small_div: '0, large_div: '0, last: 1'b1, empty: 1'b1};
         pending_pairs.push_back(word);
         return;
      end
      for (d = 1; d * d <= n && d <= 256; d++) begin
         if (n % d == 0)
            divisors.push_back(d);
      end
      foreach (divisors[i]) begin
         word.small_div = SMALL_W'(divisors[i]);
         word.large_div = IN_W'(n / divisors[i]);
         word.last      = (i == divisors.size() - 1);
         word.empty     = 1'b0;
         pending_pairs.push_back(word);
      end
   endfunction

   // Idle lengths come from three bands: mostly the shortest, sometimes the middle, rarely the longest.
   function automatic int pick_idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // Random numbers lean towards small values, since the block runs a full division
   // for every trial divisor up to the square root. A few full-width numbers exercise
   // every input bit and the longest enumerations.
   function automatic logic [IN_W-1:0] pick_number();
      int          r;
      int unsigned k;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      else if (r < 14)
         return IN_W'(1);
      else if (r < 62)
         return IN_W'($urandom_range(2, 1023));
      else if (r < 74)
         return IN_W'($urandom_range(1024, 8191));
      else if (r < 84)
         return IN_W'($urandom);
      else if (r < 93) begin
         k = $urandom_range(1, 255);
         return IN_W'(k * k);
      end else begin
         case ($urandom_range(0, 3))
            0: return IN_W'(720);
            1: return IN_W'(5040);
            2: return IN_W'(45360);
            default: return IN_W'(55440);
         endcase
      end
   endfunction

   // Offers one number on the req_ channel and returns at the edge that accepts it.
   // Valid is only lowered when a gap follows, so that a back-to-back word never sees
   // valid dropped and raised in the same step.
   task automatic offer_number(input logic [IN_W-1:0] number, input logic listed,
                               input pair_word_type typed_word);
      int gap;
      gap = 0;
      // A run of numbers in the middle goes out with no gaps at all.
      if (!(numbers_taken >= 70 && numbers_taken < 90) && $urandom_range(0, 1) == 1)
         gap = pick_idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_number_in <= number;
      do
         @(posedge clock);
      while (req_stall);
      numbers_taken++;
      if (listed)
         pending_pairs.push_back(typed_word);
      else
         enumerate_pairs(number);
   endtask

   // Receiver stalls. Every so often there is a stretch with no stalls at all, and the
   // long hold-off below forces a stall regardless.
   always @(posedge clock) begin : rsp_stall_gen
      int stall_left;
      if (stall_left == 0 && (cycle_count % 8192) >= 1024 && $urandom_range(0, 3) == 0)
         stall_left = pick_idle_length();
      rsp_stall <= hold_off || (stall_left != 0);
      if (stall_left != 0)
         stall_left--;
   end

   // Long hold-off on the result side while the sender keeps offering words, so that
   // the block backs up and has to stall its input.
   initial begin
      wait (numbers_taken >= 40);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic void compare_field(input string name, input int unsigned expected,
                                         input int unsigned actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, name, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Each accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin : result_check
      pair_word_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            $display({"%0t: unexpected word: expected none, ",
                      "actual (%0d, %0d) last %0b empty %0b"},
                     $time, rsp_small_divisor, rsp_large_divisor, rsp_last_pair,
                     rsp_no_divisors);
            mismatch_count++;
         end else begin
            expected = pending_pairs.pop_front();
            compare_field("small_divisor", expected.small_div, rsp_small_divisor);
            compare_field("large_divisor", expected.large_div, rsp_large_divisor);
            compare_field("last_pair",     expected.last,      rsp_last_pair);
            compare_field("no_divisors",   expected.empty,     rsp_no_divisors);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** divisor_pair_enumerator: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_number(directed_rows[i].number, directed_rows[i].listed, directed_rows[i].word);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         offer_number(pick_number(), 1'b0, NO_WORD);
      req_valid <= 1'b0;

      // Every number yields at least one word, so once the queue is empty the block
      // has finished; the extra cycles catch any stray words that follow.
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_pairs.size() == 0)
         $display("** divisor_pair_enumerator: PASSED **");
      else
         $display("** divisor_pair_enumerator: FAILED **");
      $finish;
   end

endmodule
